### hdl/tdrt_pkg.sv
// ----------------------------------------------------------------------------
// tdrt_pkg
// Shared widths, request and result codes, and the cell broadcast bundle for
// the tick delay release table.
// ----------------------------------------------------------------------------
package tdrt_pkg;

    localparam int ReqW   = 2;
    localparam int IdW    = 6;
    localparam int TimeW  = 32;
    localparam int KindW  = 2;

    // Task ids are six bits wide, so the table never holds more than this.
    localparam int MaxTasks = 64;

    localparam logic [ReqW-1:0] REQ_TICK  = 2'd0;
    localparam logic [ReqW-1:0] REQ_DELAY = 2'd1;
    localparam logic [ReqW-1:0] REQ_TIME  = 2'd2;

    localparam logic [KindW-1:0] KIND_TICK_ACK   = 2'd0;
    localparam logic [KindW-1:0] KIND_TIME_REPLY = 2'd1;
    localparam logic [KindW-1:0] KIND_RELEASE    = 2'd2;

    // Signals sent to every cell of the chain.
    typedef struct packed {
        logic             adv;      // token may move one cell on
        logic [TimeW-1:0] count;    // current tick count
        logic [TimeW-1:0] wr_data;  // deadline for a delay request
    } bcast_t;

endpackage

### hdl/tick_delay_release_table_core.sv
// ----------------------------------------------------------------------------
// tick_delay_release_table_core
// Tick counter with a per-task wake-up table; answers ticks and time queries
// and releases tasks whose deadline equals the count, in ascending id order.
// ----------------------------------------------------------------------------
//
//  channel | direction | beat contents                             | handshake
//  --------+-----------+-------------------------------------------+----------------
//  s_      | in        | req_type, task_id, delay_ticks            | s_valid/s_ready
//  m_      | out       | result_kind, dest_task, time_value, last  | m_valid/m_ready
//
//  Each input beat is accepted, updating the count or a deadline; the scan
//  token then walks the cell chain through every table cell, and a flush
//  sends the final result. A full output register stalls the walk when a
//  release meets a held result; s_ready stays low until the walk and flush
//  are done, but the last result may still wait in m_.
//  Reset (aresetn low, synchronous) zeroes the count and all pending bits.
//
module tick_delay_release_table_core #(
    parameter int NUM_TASKS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tdrt_pkg::ReqW-1:0]     s_req_type,
    input  logic [tdrt_pkg::IdW-1:0]      s_task_id,
    input  logic [tdrt_pkg::TimeW-1:0]    s_delay_ticks,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tdrt_pkg::KindW-1:0]    m_result_kind,
    output logic [tdrt_pkg::IdW-1:0]      m_dest_task,
    output logic [tdrt_pkg::TimeW-1:0]    m_time_value,
    output logic                          m_last
);
    import tdrt_pkg::*;

    // Ids above 63 can never be named, so the table stops there.
    localparam int TableDepth = (NUM_TASKS < MaxTasks) ? NUM_TASKS : MaxTasks;
    localparam int IdxW       = $clog2(TableDepth);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [TimeW-1:0] count_reg, count_next;
    logic [IdxW-1:0]  idx_reg, idx_next;

    // One result is held back so its last flag is known before it leaves.
    logic             held_valid_reg, held_valid_next;
    logic [KindW-1:0] held_kind_reg, held_kind_next;
    logic [IdW-1:0]   held_dest_reg, held_dest_next;

    logic             m_valid_reg, m_valid_next;
    logic [KindW-1:0] m_kind_reg;
    logic [IdW-1:0]   m_dest_reg;
    logic [TimeW-1:0] m_time_reg;
    logic             m_last_reg;

    logic                  accept;
    logic                  out_free;
    logic                  stall;
    logic                  hit_any;
    logic                  push;
    logic                  push_last;
    logic                  scan_end;
    logic [TableDepth-1:0] chain_vec;
    logic [TableDepth-1:0] hit_vec;
    bcast_t                bcast;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign hit_any  = |hit_vec;
    assign scan_end = (idx_reg == IdxW'(TableDepth - 1));

    // Hold the token where it is while a release cannot be passed on.
    assign stall = (state_reg == ST_SCAN) && hit_any && held_valid_reg && !out_free;

    assign bcast.adv     = !stall;
    assign bcast.count   = count_reg;
    assign bcast.wr_data = count_reg + s_delay_ticks;

    // Slot zero of the chain is the token source; no cell sits there.
    assign chain_vec[0] = accept;
    assign hit_vec[0]   = 1'b0;

    genvar k;
    generate
        for (k = 1; k < TableDepth; k++) begin : g_cell
            logic wr_en;
            assign wr_en = accept && (s_req_type == REQ_DELAY) && (s_task_id == IdW'(k));
            tdrt_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .bcast   (bcast),
                .wr_en   (wr_en),
                .tok_in  (chain_vec[k-1]),
                .tok_out (chain_vec[k]),
                .hit     (hit_vec[k])
            );
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        held_valid_next = held_valid_reg;
        held_kind_next  = held_kind_reg;
        held_dest_next  = held_dest_reg;
        push            = 1'b0;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next        = IdxW'(1);
                    state_next      = ST_SCAN;
                    held_valid_next = 1'b0;
                    case (s_req_type)
                        REQ_TICK: begin
                            count_next      = count_reg + 1'b1;
                            held_valid_next = 1'b1;
                            held_kind_next  = KIND_TICK_ACK;
                            held_dest_next  = '0;
                        end
                        REQ_TIME: begin
                            held_valid_next = 1'b1;
                            held_kind_next  = KIND_TIME_REPLY;
                            held_dest_next  = s_task_id;
                        end
                        default: begin
                            // delay writes the cell directly; unused code does nothing
                            held_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (hit_any) begin
                        // pass the held result on, hold the new release
                        push            = held_valid_reg;
                        held_valid_next = 1'b1;
                        held_kind_next  = KIND_RELEASE;
                        held_dest_next  = IdW'(idx_reg);
                    end
                    if (scan_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!held_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        held_kind_reg <= held_kind_next;
        held_dest_reg <= held_dest_next;
        if (push) begin
            m_kind_reg <= held_kind_reg;
            m_dest_reg <= held_dest_reg;
            m_time_reg <= count_reg;
            m_last_reg <= push_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_dest_task   = m_dest_reg;
    assign m_time_value  = m_time_reg;
    assign m_last        = m_last_reg;

    // Only one cell ever carries the scan token.
    a_tok_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(chain_vec[TableDepth-1:1]))
        else $error("scan token in more than one cell");

    // The token sits in the cell the index counter names.
    a_tok_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> chain_vec[idx_reg])
        else $error("scan token and index disagree");

    // No token and no held result while idle.
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!held_valid_reg && (chain_vec[TableDepth-1:1] == '0)))
        else $error("idle with token or held result");

    // A flush with room goes out flagged last.
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && held_valid_reg && out_free) |=> (m_valid && m_last))
        else $error("flushed result not marked last");

endmodule

### hdl/tdrt_cell.sv
// ----------------------------------------------------------------------------
// tdrt_cell
// One task slot: holds a deadline and its pending bit, compares against the
// tick count while the scan token sits here, and hands the token onward.
// ----------------------------------------------------------------------------
module tdrt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  tdrt_pkg::bcast_t bcast,
    input  logic            wr_en,
    input  logic            tok_in,
    output logic            tok_out,
    output logic            hit
);
    import tdrt_pkg::*;

    logic             tok_reg, tok_next;
    logic             pend_reg, pend_next;
    logic [TimeW-1:0] dl_reg;

    assign hit     = tok_reg && pend_reg && (dl_reg == bcast.count);
    assign tok_out = tok_reg;

    always_comb begin
        tok_next  = bcast.adv ? tok_in : tok_reg;
        pend_next = pend_reg;
        if (wr_en) begin
            pend_next = 1'b1;
        end else if (hit && bcast.adv) begin
            // drop the slot once its release goes out
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg  <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            tok_reg  <= tok_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dl_reg <= bcast.wr_data;
        end
    end

endmodule
